FILE: src/rbd_pkg.sv
package rbd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ       = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SET        = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  localparam logic signed [POS_W-1:0] POS_FRONT = -6'sd1;

  typedef struct packed {
    logic load_cmd;
    logic exec;
    logic load_out;
  } rbd_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rbd_stat_t;

endpackage

FILE: src/rbd_if.sv
interface rbd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [rbd_pkg::FUNC_W-1:0]            func;
  logic [rbd_pkg::DATA_W-1:0]            data_in;
  logic signed [rbd_pkg::POS_W-1:0]      position;

  modport source (output valid, func, data_in, position, input ready);
  modport sink   (input valid, func, data_in, position, output ready);
endinterface

interface rbd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [rbd_pkg::DATA_W-1:0]            data_out;
  logic [rbd_pkg::STATUS_W-1:0]          status;
  logic [rbd_pkg::FILL_W-1:0]            fill_level;

  modport source (output valid, data_out, status, fill_level, input ready);
  modport sink   (input valid, data_out, status, fill_level, output ready);
endinterface

FILE: src/rbd_ctrl.sv
module rbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rbd_pkg::rbd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd.load_cmd = in_valid && (state_r == S_IDLE);
    cmd.exec     = (state_r == S_EXEC);
    cmd.load_out = (state_r == S_RESP) && (!out_valid_r || out_ready);

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load_cmd) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: src/rbd_dp.sv
module rbd_dp #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbd_pkg::rbd_cmd_t                 cmd,
  input  logic [rbd_pkg::FUNC_W-1:0]        func,
  input  logic [rbd_pkg::DATA_W-1:0]        data_in,
  input  logic signed [rbd_pkg::POS_W-1:0]  position,
  output logic [rbd_pkg::DATA_W-1:0]        data_out,
  output logic [rbd_pkg::STATUS_W-1:0]      status,
  output logic [rbd_pkg::FILL_W-1:0]        fill_level,
  output rbd_pkg::rbd_stat_t                stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = CW + rbd_pkg::POS_W + 1;

  logic [rbd_pkg::FUNC_W-1:0]       func_r;
  logic [DATA_WIDTH-1:0]            data_r;
  logic signed [rbd_pkg::POS_W-1:0] pos_r;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  want_r, want_nxt;
  logic [rbd_pkg::STATUS_W-1:0] st_pend_r, st_nxt;

  logic [rbd_pkg::DATA_W-1:0]   data_out_r;
  logic [rbd_pkg::STATUS_W-1:0] status_r;
  logic [rbd_pkg::FILL_W-1:0]   fill_r;

  logic          full, empty;
  logic          pos_front, in_range, at_count;
  logic [WW-1:0] pos_w, count_w, sum_w;
  logic [PW-1:0] slot, head_prev, head_next, tail_prev, tail_next;
  logic [PW-1:0] addr;
  logic          we;
  logic          do_pf, do_pb, do_popf, do_popb, do_rd, do_rep;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  always_comb begin
    full      = (count_r == CW'(DEPTH));
    empty     = (count_r == '0);
    pos_front = (pos_r == rbd_pkg::POS_FRONT);
    pos_w     = WW'(pos_r[rbd_pkg::POS_W-1:0]);
    count_w   = WW'(count_r);
    in_range  = !pos_r[rbd_pkg::POS_W-1] && (pos_w < count_w);
    at_count  = !pos_r[rbd_pkg::POS_W-1] && (pos_w == count_w);
    sum_w     = WW'(head_r) + pos_w;
    if (sum_w >= WW'(DEPTH)) sum_w = sum_w - WW'(DEPTH);
    slot      = sum_w[PW-1:0];
    head_prev = ring_prev(head_r);
    head_next = ring_next(head_r);
    tail_prev = ring_prev(tail_r);
    tail_next = ring_next(tail_r);

    do_pf   = 1'b0;
    do_pb   = 1'b0;
    do_popf = 1'b0;
    do_popb = 1'b0;
    do_rd   = 1'b0;
    do_rep  = 1'b0;
    st_nxt  = rbd_pkg::ST_OK;
    case (func_r)
      rbd_pkg::FN_PUSH_FRONT: begin
        if (full) st_nxt = rbd_pkg::ST_FULL;
        else do_pf = 1'b1;
      end
      rbd_pkg::FN_PUSH_BACK: begin
        if (full) st_nxt = rbd_pkg::ST_FULL;
        else do_pb = 1'b1;
      end
      rbd_pkg::FN_POP_FRONT: begin
        if (empty) st_nxt = rbd_pkg::ST_EMPTY;
        else do_popf = 1'b1;
      end
      rbd_pkg::FN_POP_BACK: begin
        if (empty) st_nxt = rbd_pkg::ST_EMPTY;
        else do_popb = 1'b1;
      end
      rbd_pkg::FN_READ: begin
        if (in_range) do_rd = 1'b1;
        else st_nxt = rbd_pkg::ST_BADIDX;
      end
      rbd_pkg::FN_SET: begin
        if (pos_front) begin
          if (full) st_nxt = rbd_pkg::ST_FULL;
          else do_pf = 1'b1;
        end else if (at_count) begin
          if (full) st_nxt = rbd_pkg::ST_FULL;
          else do_pb = 1'b1;
        end else if (in_range) begin
          do_rep = 1'b1;
        end else begin
          st_nxt = rbd_pkg::ST_BADIDX;
        end
      end
      default: begin
        st_nxt = rbd_pkg::ST_BADIDX;
      end
    endcase

    if (do_pf)        addr = head_prev;
    else if (do_pb)   addr = tail_r;
    else if (do_popf) addr = head_r;
    else if (do_popb) addr = tail_prev;
    else              addr = slot;
    we       = do_pf || do_pb || do_rep;
    want_nxt = do_popf || do_popb || do_rd || do_rep;

    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_pf) begin
      head_nxt  = head_prev;
      count_nxt = count_r + 1'b1;
    end
    if (do_pb) begin
      tail_nxt  = tail_next;
      count_nxt = count_r + 1'b1;
    end
    if (do_popf) begin
      head_nxt  = head_next;
      count_nxt = count_r - 1'b1;
    end
    if (do_popb) begin
      tail_nxt  = tail_prev;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      func_r <= func;
      data_r <= DATA_WIDTH'(data_in);
      pos_r  <= position;
    end
    if (cmd.exec) begin
      want_r    <= want_nxt;
      st_pend_r <= st_nxt;
    end
    if (cmd.load_out) begin
      data_out_r <= want_r ? rbd_pkg::DATA_W'(rd_data_r) : '0;
      status_r   <= st_pend_r;
      fill_r     <= rbd_pkg::FILL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_data_r <= mem[addr];
      if (we) mem[addr] <= data_r;
    end
  end

  assign data_out   = data_out_r;
  assign status     = status_r;
  assign fill_level = fill_r;
  assign stat.empty = empty;
  assign stat.full  = full;

endmodule

FILE: src/ring_buffer_deque.sv
// Double-ended queue of DEPTH entries in a ring of single-port memory slots.
// Each command (push or pop at either end, read or set at a logical index)
// gives one result with a status and the fill level after the command. A
// command is taken while idle, uses the memory port in the execute state,
// and its registered read data reaches the output register in the response
// state, which stalls while an older result waits; only then is a new command
// taken. The result sits in an output register, so the next command is taken
// while the result waits. A push to a full queue is dropped with status full.
module ring_buffer_deque #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rbd_in_if.sink    in_ch,
  rbd_out_if.source out_ch
);

  rbd_pkg::rbd_cmd_t  cmd;
  rbd_pkg::rbd_stat_t stat;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rbd_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .func       (in_ch.func),
    .data_in    (in_ch.data_in),
    .position   (in_ch.position),
    .data_out   (out_ch.data_out),
    .status     (out_ch.status),
    .fill_level (out_ch.fill_level),
    .stat       (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("command taken while previous one in flight");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == rbd_pkg::ST_FULL
      |-> out_ch.fill_level == rbd_pkg::FILL_W'(DEPTH))
    else $error("full status with queue not full");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == rbd_pkg::ST_EMPTY |-> out_ch.fill_level == '0)
    else $error("empty status with entries held");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue both full and empty");

endmodule
